// ----- hw/rtl/ptue_pkg.sv -----
// Shared types, codes and saturating arithmetic of the particle table update engine.
package ptue_pkg;

	// Operation codes carried by the func field.
	localparam logic [1:0] FUNC_SPAWN = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_DRAW  = 2'd2;

	// Register index and reset value of the gravity register.
	localparam logic REG_GRAVITY = 1'b0;
	localparam logic signed [31:0] GRAV_RESET = -32'sd642253;

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	// Stored state of one particle, all Q16.16.
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] part_size;
		logic signed [31:0] life_limit;
		logic signed [31:0] elapsed;
	} part_t;

	// Saturating a + b or a - b on signed 32-bit values.
	function automatic logic signed [31:0] sat_addsub(input logic signed [31:0] a,
			input logic signed [31:0] b, input logic sub);
		logic signed [33:0] ea;
		logic signed [33:0] eb;
		logic signed [33:0] s;
		ea = $signed({{2{a[31]}}, a});
		eb = $signed({{2{b[31]}}, b});
		s = sub ? (ea - eb) : (ea + eb);
		if (s > $signed({{2{1'b0}}, Q_MAX})) begin
			sat_addsub = Q_MAX;
		end else if (s < $signed({{2{1'b1}}, Q_MIN})) begin
			sat_addsub = Q_MIN;
		end else begin
			sat_addsub = s[31:0];
		end
	endfunction

endpackage

// ----- hw/rtl/ptue_mulq.sv -----
// Shared Q16.16 multiplier: registered full product, then floor by 2^16 and saturation.
module ptue_mulq (
	input  logic               clk,
	input  logic signed [31:0] op_a,
	input  logic signed [31:0] op_b,
	output logic signed [31:0] q
);

	logic signed [63:0] prod_s1;

	// Full-width product, registered before the scaling step.
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	// Arithmetic shift floors; saturate when the upper bits are not a sign extension.
	always_comb begin
		if (prod_s1[63:47] == {17{1'b0}} || prod_s1[63:47] == {17{1'b1}}) begin
			q = prod_s1[47:16];
		end else if (prod_s1[63]) begin
			q = ptue_pkg::Q_MIN;
		end else begin
			q = ptue_pkg::Q_MAX;
		end
	end

endmodule

// ----- hw/rtl/ptue_store.sv -----
// Particle state store: one write port and one registered read port.
module ptue_store #(
	parameter int DEPTH = 16,
	parameter int IW = 4
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [IW-1:0]        waddr,
	input  ptue_pkg::part_t      wdata,
	input  logic [IW-1:0]        raddr,
	output ptue_pkg::part_t      rdata
);

	ptue_pkg::part_t mem_q [DEPTH];

	// Write, and registered read of the addressed slot.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/particle_table_update_engine.sv -----
// Top level of the particle table update engine: sequencer, live table and ports.
// A spawn gives one item. A tick visits every slot, updates each live slot and gives one
// item. A draw forms six products per live slot, then four corner items, one per cycle
// while the output is free; a draw with no live slot gives a single item instead. Each
// product passes through the single shared multiplier, with a multiply state and an
// accumulate state.
module particle_table_update_engine #(
	parameter int MAX_PARTICLES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [31:0] vec_a_x,
	input  logic signed [31:0] vec_a_y,
	input  logic signed [31:0] vec_a_z,
	input  logic signed [31:0] vec_b_x,
	input  logic signed [31:0] vec_b_y,
	input  logic signed [31:0] vec_b_z,
	input  logic [30:0]        spawn_size,
	input  logic [30:0]        spawn_lifespan,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] vert_x,
	output logic signed [31:0] vert_y,
	output logic signed [31:0] vert_z,
	output logic [1:0]         corner,
	output logic               vertex_valid,
	output logic [3:0]         slot,
	output logic               spawn_ok,
	output logic [4:0]         active_count,
	output logic               last
);

	localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SPAWN = 9'b000000010,
		S_RD    = 9'b000000100,
		S_LD    = 9'b000001000,
		S_MUL   = 9'b000010000,
		S_ACC   = 9'b000100000,
		S_WB    = 9'b001000000,
		S_CORN  = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	state_t                   state_q;
	logic [1:0]               func_q;
	logic signed [31:0]       ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic [30:0]              size_q, life_q;
	logic [15:0]              dt_q;
	logic signed [31:0]       grav_q;
	logic [MAX_PARTICLES-1:0] live_q;
	logic [4:0]               cnt_q;
	logic [IW-1:0]            slot_q;
	logic [2:0]               mstep_q;
	logic [1:0]               corner_q;
	ptue_pkg::part_t          w_q;
	logic signed [31:0]       rx_q, ry_q, rz_q, ux_q, uy_q, uz_q;
	logic [3:0]               res_slot_q;
	logic                     res_ok_q;

	logic                     in_acc;
	logic                     out_free;
	logic                     at_end;
	state_t                   adv_state;
	logic                     free_found;
	logic [IW-1:0]            free_idx;
	logic                     live_above;
	logic signed [31:0]       op_a, op_b, mq;
	ptue_pkg::part_t          rd, wdata, wb_part;
	logic                     we;
	logic [IW-1:0]            waddr;
	logic                     retire;
	logic                     rsub, usub;
	logic signed [31:0]       cx, cy, cz;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ptue_pkg::REG_GRAVITY) ? grav_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= ptue_pkg::GRAV_RESET;
		end else if (psel && penable && pwrite && paddr[2] == ptue_pkg::REG_GRAVITY) begin
			grav_q <= pwdata;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign at_end   = (slot_q == IW'(MAX_PARTICLES - 1));
	assign adv_state = at_end ? ((func_q == ptue_pkg::FUNC_TICK) ? S_EMIT : S_IDLE) : S_RD;

	// Lowest free slot, and whether a live slot lies above the current one.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		live_above = 1'b0;
		for (int i = MAX_PARTICLES - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
			if (live_q[i] && (IW'(i) > slot_q)) begin
				live_above = 1'b1;
			end
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		if (func_q == ptue_pkg::FUNC_TICK) begin
			op_a = $signed({16'd0, dt_q});
			case (mstep_q)
				3'd0:    op_b = grav_q;
				3'd1:    op_b = w_q.vel_x;
				3'd2:    op_b = w_q.vel_y;
				default: op_b = w_q.vel_z;
			endcase
		end else begin
			op_a = $signed({1'b0, w_q.part_size[31:1]});
			case (mstep_q)
				3'd0:    op_b = ax_q;
				3'd1:    op_b = ay_q;
				3'd2:    op_b = az_q;
				3'd3:    op_b = bx_q;
				3'd4:    op_b = by_q;
				default: op_b = bz_q;
			endcase
		end
	end

	ptue_mulq u_mulq (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.q    (mq)
	);

	// End-of-tick update of one particle: floor bounce, ageing and retirement.
	always_comb begin
		wb_part = w_q;
		if (w_q.pos_z <= 32'sd0) begin
			wb_part.pos_z = 32'sd0;
			wb_part.vel_z = ptue_pkg::sat_addsub(32'sd0, w_q.vel_z, 1'b1);
		end
		wb_part.elapsed = ptue_pkg::sat_addsub(w_q.elapsed, $signed({16'd0, dt_q}), 1'b0);
		retire = (wb_part.elapsed >= w_q.life_limit);
	end

	// Store write port: spawn writes a fresh particle, a tick writes back.
	always_comb begin
		we    = 1'b0;
		waddr = slot_q;
		wdata = wb_part;
		if (state_q == S_SPAWN) begin
			we               = free_found;
			waddr            = free_idx;
			wdata.pos_x      = ax_q;
			wdata.pos_y      = ay_q;
			wdata.pos_z      = az_q;
			wdata.vel_x      = bx_q;
			wdata.vel_y      = by_q;
			wdata.vel_z      = bz_q;
			wdata.part_size  = $signed({1'b0, size_q});
			wdata.life_limit = $signed({1'b0, life_q});
			wdata.elapsed    = 32'sd0;
		end else if (state_q == S_WB) begin
			we = 1'b1;
		end
	end

	ptue_store #(
		.DEPTH (MAX_PARTICLES),
		.IW    (IW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (slot_q),
		.rdata (rd)
	);

	// Billboard corner from position and the scaled right and up vectors.
	always_comb begin
		rsub = !(corner_q == 2'd1 || corner_q == 2'd2);
		usub = !corner_q[1];
		cx = ptue_pkg::sat_addsub(ptue_pkg::sat_addsub(w_q.pos_x, rx_q, rsub), ux_q, usub);
		cy = ptue_pkg::sat_addsub(ptue_pkg::sat_addsub(w_q.pos_y, ry_q, rsub), uy_q, usub);
		cz = ptue_pkg::sat_addsub(ptue_pkg::sat_addsub(w_q.pos_z, rz_q, rsub), uz_q, usub);
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			live_q     <= '0;
			cnt_q      <= '0;
			slot_q     <= '0;
			mstep_q    <= '0;
			corner_q   <= '0;
			func_q     <= '0;
			res_slot_q <= '0;
			res_ok_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						func_q     <= func;
						slot_q     <= '0;
						res_slot_q <= '0;
						res_ok_q   <= 1'b0;
						unique case (func)
							ptue_pkg::FUNC_SPAWN: state_q <= S_SPAWN;
							ptue_pkg::FUNC_TICK:  state_q <= S_RD;
							ptue_pkg::FUNC_DRAW:  state_q <= (cnt_q == 5'd0) ? S_EMIT : S_RD;
							default:              state_q <= S_EMIT;
						endcase
					end
				end
				S_SPAWN: begin
					if (free_found) begin
						live_q[free_idx] <= 1'b1;
						cnt_q            <= cnt_q + 5'd1;
						res_slot_q       <= 4'(free_idx);
						res_ok_q         <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_RD: begin
					if (live_q[slot_q]) begin
						state_q <= S_LD;
					end else begin
						state_q <= adv_state;
						if (!at_end) begin
							slot_q <= slot_q + 1'b1;
						end
					end
				end
				S_LD: begin
					mstep_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (func_q == ptue_pkg::FUNC_TICK) begin
						state_q <= (mstep_q == 3'd3) ? S_WB : S_MUL;
					end else begin
						state_q <= (mstep_q == 3'd5) ? S_CORN : S_MUL;
						corner_q <= '0;
					end
					mstep_q <= mstep_q + 3'd1;
				end
				S_WB: begin
					if (retire) begin
						live_q[slot_q] <= 1'b0;
						cnt_q          <= cnt_q - 5'd1;
					end
					state_q <= adv_state;
					if (!at_end) begin
						slot_q <= slot_q + 1'b1;
					end
				end
				S_CORN: begin
					if (out_free) begin
						corner_q <= corner_q + 2'd1;
						if (corner_q == 2'd3) begin
							state_q <= adv_state;
							if (!at_end) begin
								slot_q <= slot_q + 1'b1;
							end
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Input capture and working registers of the current particle.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ax_q   <= vec_a_x;
			ay_q   <= vec_a_y;
			az_q   <= vec_a_z;
			bx_q   <= vec_b_x;
			by_q   <= vec_b_y;
			bz_q   <= vec_b_z;
			size_q <= spawn_size;
			life_q <= spawn_lifespan;
			dt_q   <= time_step;
		end
		if (state_q == S_LD) begin
			w_q <= rd;
		end
		if (state_q == S_ACC) begin
			if (func_q == ptue_pkg::FUNC_TICK) begin
				case (mstep_q)
					3'd0:    w_q.vel_z <= ptue_pkg::sat_addsub(w_q.vel_z, mq, 1'b0);
					3'd1:    w_q.pos_x <= ptue_pkg::sat_addsub(w_q.pos_x, mq, 1'b0);
					3'd2:    w_q.pos_y <= ptue_pkg::sat_addsub(w_q.pos_y, mq, 1'b0);
					default: w_q.pos_z <= ptue_pkg::sat_addsub(w_q.pos_z, mq, 1'b0);
				endcase
			end else begin
				case (mstep_q)
					3'd0:    rx_q <= mq;
					3'd1:    ry_q <= mq;
					3'd2:    rz_q <= mq;
					3'd3:    ux_q <= mq;
					3'd4:    uy_q <= mq;
					default: uz_q <= mq;
				endcase
			end
		end
	end

	// Output register: a result item waits here until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == S_EMIT || state_q == S_CORN) && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == S_EMIT) begin
			vert_x       <= 32'sd0;
			vert_y       <= 32'sd0;
			vert_z       <= 32'sd0;
			corner       <= 2'd0;
			vertex_valid <= 1'b0;
			slot         <= res_slot_q;
			spawn_ok     <= res_ok_q;
			active_count <= cnt_q;
			last         <= 1'b1;
		end else if (out_free && state_q == S_CORN) begin
			vert_x       <= cx;
			vert_y       <= cy;
			vert_z       <= cz;
			corner       <= corner_q;
			vertex_valid <= 1'b1;
			slot         <= 4'(slot_q);
			spawn_ok     <= 1'b0;
			active_count <= cnt_q;
			last         <= (corner_q == 2'd3) && !live_above;
		end
	end

	// The running count always matches the live table.
	a_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 5'($countones(live_q)))
		else $error("active count differs from live table");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 5'(MAX_PARTICLES))
		else $error("active count above table depth");

	// Corners are only produced for a live slot.
	a_corn_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CORN |-> live_q[slot_q])
		else $error("corner item for a slot that is not live");

endmodule
